>>> hdl/parametric_curve_point_tangent_assert.svh
// Assertion macros shared by the curve evaluator modules
`ifndef PARAMETRIC_CURVE_POINT_TANGENT_ASSERT_SVH
`define PARAMETRIC_CURVE_POINT_TANGENT_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent.
`define PCT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pct: same-cycle check failed");

// Check a consequence in the cycle after its antecedent.
`define PCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pct: next-cycle check failed");

`endif

>>> hdl/pct_pkg.sv
// Shared constants, types and functions of the curve evaluator
package pct_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int FRAC_BITS     = 16;
    localparam int DATA_W        = 32;
    localparam int XY_W          = 34;
    localparam int Z_W           = 34;
    localparam int RAD_W         = 34;
    localparam int STAGE_W       = $clog2(CORDIC_STAGES);
    localparam int CFG_IDX_W     = 3;
    localparam int OUT_W         = 6 * DATA_W;

    localparam logic [63:0]             INV_2PI_Q64 = 64'h28BE_60DB_9391_054A;
    localparam logic signed [XY_W-1:0]  CORDIC_GAIN = 34'sd652032875;

    localparam logic [CFG_IDX_W-1:0] REG_KIND   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CX     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RA     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RB     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RISE   = 3'd5;

    localparam logic [1:0] KIND_CIRCLE  = 2'd0;
    localparam logic [1:0] KIND_ELLIPSE = 2'd1;
    localparam logic [1:0] KIND_HELIX   = 2'd2;

    typedef struct packed {
        logic signed [XY_W-1:0]   x;
        logic signed [XY_W-1:0]   y;
        logic signed [Z_W-1:0]    z;
        logic                     flip;
        logic signed [DATA_W-1:0] angle;
    } t_rot;

    typedef struct packed {
        logic                     helix;
        logic signed [RAD_W-1:0]  ra;
        logic signed [RAD_W-1:0]  nra;
        logic signed [RAD_W-1:0]  rb;
        logic signed [DATA_W-1:0] cx;
        logic signed [DATA_W-1:0] cy;
        logic signed [DATA_W-1:0] rise;
    } t_curve;

    // atan(2^-i) in turns, Q0.32, rounded to nearest
    function automatic logic [31:0] atan_turns(input logic [STAGE_W-1:0] i);
        logic [63:0] v;
        v = ((INV_2PI_Q64 >> (7'd31 + 7'(i))) + 64'd1) >> 1;
        unique case (i)
            STAGE_W'(0): return 32'd536870912;
            STAGE_W'(1): return 32'd316933406;
            STAGE_W'(2): return 32'd167458907;
            STAGE_W'(3): return 32'd85004756;
            STAGE_W'(4): return 32'd42667331;
            STAGE_W'(5): return 32'd21354465;
            STAGE_W'(6): return 32'd10679838;
            STAGE_W'(7): return 32'd5340245;
            STAGE_W'(8): return 32'd2670163;
            STAGE_W'(9): return 32'd1335087;
            default:     return v[31:0];
        endcase
    endfunction

endpackage

>>> hdl/pct_phase.sv
// Range reduction of the angle to a folded CORDIC start vector
module pct_phase (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [pct_pkg::DATA_W-1:0] i_angle,
    output logic                          o_valid,
    input  logic                          i_ready,
    output pct_pkg::t_rot                 o_data
);

    localparam int SUM_W = pct_pkg::FRAC_BITS + 32;

    logic                            r_v1, r_v2, r_v3;
    logic                            r_neg1, r_neg2;
    logic [31:0]                     r_mag1;
    logic [63:0]                     r_p2_1, r_p2_2, r_p1_2;
    logic signed [pct_pkg::DATA_W-1:0] r_ang1, r_ang2;
    pct_pkg::t_rot                   r_d3;

    logic          rdy1, rdy2, rdy3;
    logic [31:0]   n_mag;
    logic [63:0]   n_p2, n_p1;
    logic [SUM_W-1:0] n_sum;
    logic [31:0]   n_phase_abs, n_phase, n_turn, n_fold;
    pct_pkg::t_rot n_d3;

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v3;
    assign o_data  = r_d3;

    always_comb begin
        n_mag = i_angle[pct_pkg::DATA_W-1] ? (32'd0 - 32'(i_angle)) : 32'(i_angle);
        n_p2  = 64'(n_mag) * 64'(pct_pkg::INV_2PI_Q64[31:0]);
        n_p1  = 64'(r_mag1) * 64'(pct_pkg::INV_2PI_Q64[63:32]);
    end

    always_comb begin
        n_sum       = r_p1_2[SUM_W-1:0] + SUM_W'(r_p2_2[63:32]);
        n_phase_abs = n_sum[pct_pkg::FRAC_BITS +: 32];
        n_phase     = r_neg2 ? (32'd0 - n_phase_abs) : n_phase_abs;
        n_turn      = n_phase + 32'h4000_0000;
        n_fold      = n_phase ^ {n_turn[31], 31'd0};
        n_d3.x      = pct_pkg::CORDIC_GAIN;
        n_d3.y      = '0;
        n_d3.z      = pct_pkg::Z_W'($signed(n_fold));
        n_d3.flip   = n_turn[31];
        n_d3.angle  = r_ang2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_neg1 <= i_angle[pct_pkg::DATA_W-1];
            r_mag1 <= n_mag;
            r_p2_1 <= n_p2;
            r_ang1 <= i_angle;
        end
        if (rdy2 && r_v1) begin
            r_neg2 <= r_neg1;
            r_p1_2 <= n_p1;
            r_p2_2 <= r_p2_1;
            r_ang2 <= r_ang1;
        end
        if (rdy3 && r_v2) begin
            r_d3 <= n_d3;
        end
    end

`include "parametric_curve_point_tangent_assert.svh"

`PCT_ASSERT_NOW(a_fold_range, i_clk, i_rst_n, r_v3, (r_d3.z[pct_pkg::Z_W-1:30] == '0) || (r_d3.z[pct_pkg::Z_W-1:30] == '1))
`PCT_ASSERT_NEXT(a_front_hold, i_clk, i_rst_n, r_v3 && !i_ready, r_v3 && $stable(r_d3))

endmodule

>>> hdl/pct_cordic_cell.sv
// One CORDIC rotation cell with its own valid and stall handling
module pct_cordic_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [pct_pkg::STAGE_W-1:0]   i_stage,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  pct_pkg::t_rot                 i_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output pct_pkg::t_rot                 o_data
);

    logic                              r_valid;
    pct_pkg::t_rot                     r_data;
    pct_pkg::t_rot                     n_data;
    logic signed [pct_pkg::XY_W-1:0]   dx, dy;
    logic signed [pct_pkg::Z_W-1:0]    ang;
    logic                              z_neg;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        dx     = i_data.y >>> i_stage;
        dy     = i_data.x >>> i_stage;
        ang    = $signed({{(pct_pkg::Z_W-32){1'b0}}, pct_pkg::atan_turns(i_stage)});
        z_neg  = i_data.z[pct_pkg::Z_W-1];
        n_data = i_data;
        if (z_neg) begin
            n_data.x = i_data.x + dx;
            n_data.y = i_data.y - dy;
            n_data.z = i_data.z + ang;
        end else begin
            n_data.x = i_data.x - dx;
            n_data.y = i_data.y + dy;
            n_data.z = i_data.z - ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

`include "parametric_curve_point_tangent_assert.svh"

`PCT_ASSERT_NEXT(a_cell_hold, i_clk, i_rst_n, r_valid && !i_ready, r_valid && $stable(r_data))
`PCT_ASSERT_NEXT(a_cell_load, i_clk, i_rst_n, i_valid && o_ready, r_valid)

endmodule

>>> hdl/pct_output.sv
// Radius and rise products, rounding, center offset and saturation into the output register
module pct_output (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pct_pkg::t_curve               i_curve,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  pct_pkg::t_rot                 i_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [pct_pkg::OUT_W-1:0]     o_data
);

    localparam int PW  = pct_pkg::RAD_W + pct_pkg::XY_W;
    localparam int ZPW = 2 * pct_pkg::DATA_W;

    function automatic logic signed [PW-31:0] rnd30(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = p + (PW'(1) <<< 29);
        return $signed(t[PW-1:30]);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'h8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

    logic                          r_v1, r_v2;
    logic signed [PW-1:0]          r_pxc, r_pys, r_sxs, r_syc;
    logic signed [ZPW-1:0]         r_pz;
    logic [pct_pkg::OUT_W-1:0]     r_out;

    logic                          rdy1, rdy2;
    logic signed [pct_pkg::XY_W-1:0] n_c, n_s;
    logic signed [ZPW-1:0]         n_zr;
    logic [31:0]                   n_px, n_py, n_pz, n_sx, n_sy, n_sz;

    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v2;
    assign o_data  = r_out;

    always_comb begin
        n_c = i_data.flip ? -i_data.x : i_data.x;
        n_s = i_data.flip ? -i_data.y : i_data.y;
    end

    always_comb begin
        n_zr = r_pz + (ZPW'(1) <<< (pct_pkg::FRAC_BITS - 1));
        n_px = sat32(64'(i_curve.cx) + 64'(rnd30(r_pxc)));
        n_py = sat32(64'(i_curve.cy) + 64'(rnd30(r_pys)));
        n_sx = sat32(64'(rnd30(r_sxs)));
        n_sy = sat32(64'(rnd30(r_syc)));
        n_pz = i_curve.helix ? sat32(64'($signed(n_zr[ZPW-1:pct_pkg::FRAC_BITS]))) : 32'd0;
        n_sz = i_curve.helix ? 32'(i_curve.rise) : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_pxc <= PW'(i_curve.ra) * PW'(n_c);
            r_pys <= PW'(i_curve.rb) * PW'(n_s);
            r_sxs <= PW'(i_curve.nra) * PW'(n_s);
            r_syc <= PW'(i_curve.rb) * PW'(n_c);
            r_pz  <= ZPW'(i_curve.rise) * ZPW'(i_data.angle);
        end
        if (rdy2 && r_v1) begin
            r_out <= {n_sz, n_sy, n_sx, n_pz, n_py, n_px};
        end
    end

`include "parametric_curve_point_tangent_assert.svh"

`PCT_ASSERT_NEXT(a_out_fill, i_clk, i_rst_n, r_v1 && rdy2, r_v2)

endmodule

>>> hdl/parametric_curve_point_tangent.sv
// Top level: configuration registers, range reduction, CORDIC cell row and output stage
//
//  channel   direction  ports                        payload (low bit first)
//  s_axis    in         i_s_axis_tvalid/o_..tready   tdata[31:0] angle
//  m_axis    out        o_m_axis_tvalid/i_..tready   point_x, point_y, point_z,
//                                                    slope_x, slope_y, slope_z
//  cfg       in         i_cfg_we/index/data          one register per write
//
//  One item per cycle while the output is not stalled; the path is registered
//  through range reduction, the CORDIC cell row and the output stage.
//  Synchronous active-low reset empties every stage and loads register defaults.
//  A stalled output holds its transfer; earlier stages keep filling bubbles.
module parametric_curve_point_tangent (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [31:0]                       i_s_axis_tdata,  // angle
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [pct_pkg::OUT_W-1:0]         o_m_axis_tdata,  // point_x, point_y, point_z,
                                                               // slope_x, slope_y, slope_z
    input  logic                              i_cfg_we,
    input  logic [pct_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);

    localparam int N = pct_pkg::CORDIC_STAGES;

    logic [1:0]                        r_kind;
    logic signed [pct_pkg::DATA_W-1:0] r_cx, r_cy, r_ra, r_rb, r_rise;

    pct_pkg::t_curve                   curve;
    logic signed [pct_pkg::RAD_W-1:0]  abs_a, abs_b;

    logic          w_valid [0:N];
    logic          w_ready [0:N];
    pct_pkg::t_rot w_data  [0:N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= pct_pkg::KIND_CIRCLE;
            r_cx   <= '0;
            r_cy   <= '0;
            r_ra   <= 32'sd65536;
            r_rb   <= 32'sd65536;
            r_rise <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pct_pkg::REG_KIND: r_kind <= i_cfg_data[1:0];
                pct_pkg::REG_CX:   r_cx   <= i_cfg_data;
                pct_pkg::REG_CY:   r_cy   <= i_cfg_data;
                pct_pkg::REG_RA:   r_ra   <= i_cfg_data;
                pct_pkg::REG_RB:   r_rb   <= i_cfg_data;
                pct_pkg::REG_RISE: r_rise <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        abs_a = r_ra[31] ? -pct_pkg::RAD_W'(r_ra) : pct_pkg::RAD_W'(r_ra);
        abs_b = r_rb[31] ? -pct_pkg::RAD_W'(r_rb) : pct_pkg::RAD_W'(r_rb);
        curve.helix = (r_kind == pct_pkg::KIND_HELIX);
        curve.cx    = r_cx;
        curve.cy    = r_cy;
        curve.rise  = r_rise;
        priority if (r_kind == pct_pkg::KIND_HELIX) begin
            curve.ra = pct_pkg::RAD_W'(r_ra);
            curve.rb = pct_pkg::RAD_W'(r_ra);
        end else if (r_kind == pct_pkg::KIND_ELLIPSE) begin
            curve.ra = abs_a;
            curve.rb = abs_b;
        end else begin
            curve.ra = abs_a;
            curve.rb = abs_a;
        end
        curve.nra = -curve.ra;
    end

    pct_phase u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_angle ($signed(i_s_axis_tdata)),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_data  (w_data[0])
    );

    for (genvar g = 0; g < N; g++) begin : g_cell
        pct_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (pct_pkg::STAGE_W'(g)),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_data  (w_data[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    pct_output u_output (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_curve (curve),
        .i_valid (w_valid[N]),
        .o_ready (w_ready[N]),
        .i_data  (w_data[N]),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

endmodule
